// ----- rtl/core/mbf_pkg.sv -----
// Shared types and constants for the 2x2 box-filter mipmap chain.
`timescale 1ns / 1ps

package mbf_pkg;

	localparam int CH_W      = 8;
	localparam int NUM_CH    = 4;
	localparam int SUM_W     = CH_W + 1;
	localparam int COORD_W   = 9;
	localparam int LEVEL_W   = 4;
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);

	localparam logic [LEVEL_W-1:0] NUM_LEVELS_RST = LEVEL_W'(10);

	typedef logic [NUM_CH-1:0][CH_W-1:0]  pix_t;
	typedef logic [NUM_CH-1:0][SUM_W-1:0] sum_t;

	// pixel handed from one level cell to the next smaller level
	typedef struct packed {
		logic valid;
		pix_t pix;
	} down_t;

	// status a cell reports back up the chain
	typedef struct packed {
		logic stall;
		logic emit;
	} up_t;

	// one queued result of a cell
	typedef struct packed {
		logic                last;
		logic [COORD_W-1:0]  x_pos;
		logic [COORD_W-1:0]  y_pos;
		pix_t                pix;
	} res_t;

endpackage

// ----- rtl/core/mbf_cell.sv -----
// One level cell: counters, pending pixel, pair-sum row memory, averager and result queue.
`timescale 1ns / 1ps

module mbf_cell import mbf_pkg::*; #(
	parameter int SLOT = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  clr,
	input  down_t in_i,
	output up_t   up_o,
	output down_t down_o,
	input  up_t   next_up_i,
	input  logic  pop,
	output logic  head_valid,
	output res_t  head
);

	localparam int CW    = SLOT + 1;
	localparam int AW    = (SLOT > 0) ? SLOT : 1;
	localparam int DEPTH = 1 << SLOT;
	localparam logic [SUM_W:0] ROUND = (SUM_W+1)'(2);

	logic [CW-1:0]      x_q, y_q;
	pix_t               pend_q;
	sum_t               row_mem [DEPTH];
	sum_t               above_q;
	sum_t               pair;
	sum_t               pair_s1;
	logic [COORD_W-1:0] xh_s1, yh_s1;
	logic               valid_s1;
	logic [AW-1:0]      addr;
	logic               accept, emit, leave, fifo_full;
	logic [SUM_W:0]     tot [NUM_CH];
	pix_t               avg;

	res_t                fifo_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [RES_PTR_W:0]   cnt_q;

	assign emit      = x_q[0] & y_q[0];
	assign fifo_full = (cnt_q == (RES_PTR_W+1)'(RES_DEPTH));
	assign leave     = valid_s1 && !next_up_i.stall && !fifo_full;
	assign up_o.stall = valid_s1 && !leave;
	assign up_o.emit  = emit;
	assign accept    = in_i.valid && !up_o.stall;
	assign addr      = AW'(x_q >> 1);

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			pair[c] = SUM_W'(pend_q[c]) + SUM_W'(in_i.pix[c]);
			tot[c]  = (SUM_W+1)'(above_q[c]) + (SUM_W+1)'(pair_s1[c]) + ROUND;
			avg[c]  = tot[c][SUM_W:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (clr) begin
			x_q <= '0;
			y_q <= '0;
		end else if (accept) begin
			x_q <= x_q + CW'(1);
			if (x_q == '1) begin
				y_q <= y_q + CW'(1);
			end
		end
	end

	// even column: hold the left pixel
	always_ff @(posedge clk) begin
		if (accept && !x_q[0]) begin
			pend_q <= in_i.pix;
		end
	end

	// odd column, even row: park the horizontal pair sum for the row below
	always_ff @(posedge clk) begin
		if (accept && x_q[0] && !y_q[0]) begin
			row_mem[addr] <= pair;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			above_q <= row_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			pair_s1 <= pair;
			xh_s1   <= COORD_W'(x_q >> 1);
			yh_s1   <= COORD_W'(y_q >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && emit) begin
			valid_s1 <= 1'b1;
		end else if (leave) begin
			valid_s1 <= 1'b0;
		end
	end

	assign down_o.valid = valid_s1 && !fifo_full;
	assign down_o.pix   = avg;

	// result queue; the cell below tells whether the cascade goes on
	always_ff @(posedge clk) begin
		if (leave) begin
			fifo_q[wr_ptr_q] <= '{last: !next_up_i.emit, x_pos: xh_s1, y_pos: yh_s1, pix: avg};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (leave) begin
				wr_ptr_q <= wr_ptr_q + RES_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			unique case ({leave, pop})
				2'b10:   cnt_q <= cnt_q + (RES_PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (RES_PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head_valid = (cnt_q != '0);
	assign head       = fifo_q[rd_ptr_q];

endmodule

// ----- rtl/core/mipmap_box_filter_chain_top.sv -----
// Top level of the 2x2 box-filter mipmap chain: level cells, result sequencer, output register.
`timescale 1ns / 1ps

// Accepts one top-level pixel per cycle while in_stall is low, in raster order, and emits,
// for every completed 2x2 block at any level, the averaged pixel of the next smaller level,
// tagged with its level and position. One cell per level sits in a chain; a pixel enters
// the cell of the top level and each emitted average moves to the cell below after one
// register stage, which also holds the registered row-memory read. Each cell queues up to
// four results; a sequencer drains them in cascade order, one result per cycle while
// out_stall is low, with last_of_run on the final result of a pixel. in_stall rises only
// while the top cell's stage is held by a full result queue in it or in a cell below,
// which happens after bursts of long cascades. Writing num_levels clears the cells' position
// counters; values above MAX_LEVELS count as MAX_LEVELS, and zero levels produce no results.
module mipmap_box_filter_chain_top import mbf_pkg::*; #(
	parameter int MAX_LEVELS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LEVEL_W-1:0] cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CH_W-1:0]    channel_0,
	input  logic [CH_W-1:0]    channel_1,
	input  logic [CH_W-1:0]    channel_2,
	input  logic [CH_W-1:0]    channel_3,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [LEVEL_W-1:0] level,
	output logic [COORD_W-1:0] x_pos,
	output logic [COORD_W-1:0] y_pos,
	output logic [CH_W-1:0]    out_channel_0,
	output logic [CH_W-1:0]    out_channel_1,
	output logic [CH_W-1:0]    out_channel_2,
	output logic [CH_W-1:0]    out_channel_3,
	output logic               last_of_run
);

	localparam int SW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int RST_LV = (MAX_LEVELS < 10) ? MAX_LEVELS : 10;
	localparam logic [SW-1:0] RESET_TOP = SW'(RST_LV - 1);
	localparam logic [LEVEL_W-1:0] MAX_LV = LEVEL_W'(MAX_LEVELS);

	logic [LEVEL_W-1:0]    num_levels_q;
	logic [LEVEL_W-1:0]    lv_eff, lv_wr;
	logic [SW-1:0]         top_idx, top_wr;
	pix_t                  in_pix;

	down_t                 cin    [MAX_LEVELS];
	down_t                 cout   [MAX_LEVELS];
	up_t                   cup    [MAX_LEVELS];
	up_t                   cnext  [MAX_LEVELS];
	res_t                  head   [MAX_LEVELS];
	logic [MAX_LEVELS-1:0] head_valid;
	logic [MAX_LEVELS-1:0] pop;

	logic [SW-1:0]         seq_q;
	res_t                  head_sel;
	logic                  sel_valid, load, in_stall_c;

	logic                  out_valid_q, last_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [COORD_W-1:0]    x_q, y_q;
	pix_t                  pix_q;

	assign in_pix = {channel_3, channel_2, channel_1, channel_0};

	// with zero levels park the sequencer on the bottom cell, which stays empty
	always_comb begin
		lv_eff  = (num_levels_q > MAX_LV) ? MAX_LV : num_levels_q;
		lv_wr   = (cfg_wr_data > MAX_LV) ? MAX_LV : cfg_wr_data;
		top_idx = (lv_eff == '0) ? '0 : SW'(lv_eff - LEVEL_W'(1));
		top_wr  = (lv_wr == '0) ? '0 : SW'(lv_wr - LEVEL_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_levels_q <= NUM_LEVELS_RST;
		end else if (cfg_wr_en) begin
			num_levels_q <= cfg_wr_data;
		end
	end

	// route the input beat to the top active cell, otherwise take the cell above
	for (genvar s = 0; s < MAX_LEVELS; s++) begin : g_cell
		if (s == MAX_LEVELS - 1) begin : g_first
			assign cin[s].valid = (LEVEL_W'(s + 1) == lv_eff) && in_valid;
			assign cin[s].pix   = in_pix;
		end else begin : g_chain
			assign cin[s].valid = (LEVEL_W'(s + 1) == lv_eff) ? in_valid :
			                      (LEVEL_W'(s + 1) < lv_eff) && cout[s+1].valid;
			assign cin[s].pix   = (LEVEL_W'(s + 1) == lv_eff) ? in_pix : cout[s+1].pix;
		end

		if (s == 0) begin : g_last
			assign cnext[s] = '0;
		end else begin : g_below
			assign cnext[s] = cup[s-1];
		end

		mbf_cell #(
			.SLOT(s)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.clr       (cfg_wr_en),
			.in_i      (cin[s]),
			.up_o      (cup[s]),
			.down_o    (cout[s]),
			.next_up_i (cnext[s]),
			.pop       (pop[s]),
			.head_valid(head_valid[s]),
			.head      (head[s])
		);
	end

	always_comb begin
		in_stall_c = 1'b0;
		for (int s = 0; s < MAX_LEVELS; s++) begin
			if (LEVEL_W'(s + 1) == lv_eff) begin
				in_stall_c = cup[s].stall;
			end
		end
	end

	assign in_stall = in_stall_c;

	// sequencer: walk down the cells of one cascade, then back to the top
	assign head_sel  = head[seq_q];
	assign sel_valid = head_valid[seq_q];
	assign load      = sel_valid && (!out_valid_q || !out_stall);
	assign pop       = load ? (MAX_LEVELS'(1) << seq_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= RESET_TOP;
		end else if (cfg_wr_en) begin
			seq_q <= top_wr;
		end else if (load) begin
			seq_q <= head_sel.last ? top_idx : seq_q - SW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			level_q <= LEVEL_W'(seq_q);
			x_q     <= head_sel.x_pos;
			y_q     <= head_sel.y_pos;
			pix_q   <= head_sel.pix;
			last_q  <= head_sel.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign level         = level_q;
	assign x_pos         = x_q;
	assign y_pos         = y_q;
	assign out_channel_0 = pix_q[0];
	assign out_channel_1 = pix_q[1];
	assign out_channel_2 = pix_q[2];
	assign out_channel_3 = pix_q[3];
	assign last_of_run   = last_q;

	// the smallest level always ends its cascade
	a_level0_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> level != '0)
		else $error("cascade continues past the 1x1 level");

	a_pop_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pop))
		else $error("more than one result queue popped");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(pop != '0) |-> ((pop & head_valid) == pop))
		else $error("pop of an empty result queue");

endmodule
